/* rtl/rcpsd_pkg.sv */
// ----------------------------------------------------------------------------
// rcpsd_pkg
// Types, constants and helper functions for the stick packet decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rcpsd_pkg;

	// configuration register indexes
	localparam int unsigned CfgAddrW = 2;
	localparam logic [CfgAddrW-1:0] REG_ID_LOW  = 2'd0;
	localparam logic [CfgAddrW-1:0] REG_ID_HIGH = 2'd1;

	// payload byte positions that carry data
	localparam int unsigned ByteFirst   = 9;
	localparam int unsigned ByteLast    = 17;
	localparam int unsigned BYTE_ROLL_L = 9;
	localparam int unsigned BYTE_ROLL_H = 10;
	localparam int unsigned BYTE_PIT_L  = 11;
	localparam int unsigned BYTE_PIT_H  = 12;
	localparam int unsigned BYTE_THR_L  = 13;
	localparam int unsigned BYTE_THR_H  = 14;
	localparam int unsigned BYTE_YAW_L  = 15;
	localparam int unsigned BYTE_FLAGS  = 16;
	localparam int unsigned BYTE_MODE   = 17;

	localparam int unsigned FLIP_BIT = 4;

	// command ranges
	localparam logic [15:0]        THR_LOW   = 16'd1000;
	localparam logic [15:0]        THR_HIGH  = 16'd2000;
	localparam logic signed [16:0] STICK_MID = 17'sd1500;
	localparam logic signed [16:0] STICK_LIM = 17'sd500;
	localparam logic signed [9:0]  AUX_POS   = 10'sd500;
	localparam logic signed [9:0]  AUX_NEG   = -10'sd500;
	localparam logic signed [9:0]  FLIP_LIM  = 10'sd450;

	// rate fractions as 16-bit reciprocals; exact after truncation for |v| <= 500
	localparam logic [15:0] MUL_33 = 16'd21627;
	localparam logic [15:0] MUL_66 = 16'd43254;

	// hop table offsets
	localparam logic [6:0] HOP_OFS0 = 7'h03;
	localparam logic [6:0] HOP_OFS1 = 7'h16;
	localparam logic [6:0] HOP_OFS2 = 7'h2D;
	localparam logic [6:0] HOP_OFS3 = 7'h40;
	localparam logic [1:0] HOP_RESET = 2'd1;

	localparam logic [7:0] MODE_33_CODE = 8'h00;
	localparam logic [7:0] MODE_66_CODE = 8'h01;

	typedef enum logic [1:0] {
		RATE_33,
		RATE_66,
		RATE_ONE
	} rate_t;

	// decoded packet held between the two stages
	typedef struct packed {
		logic [9:0]        thr;
		logic signed [9:0] roll;
		logic signed [9:0] pitch;
		logic signed [9:0] yaw;
		logic signed [9:0] aux;
		logic [6:0]        hop;
		rate_t             mode;
	} cmd_t;

	// offset stick word clamped to +-500
	function automatic logic signed [9:0] clamp_stick(input logic signed [16:0] d);
		logic signed [9:0] r;
		if (d < -STICK_LIM) begin
			r = -10'sd500;
		end else if (d > STICK_LIM) begin
			r = 10'sd500;
		end else begin
			r = 10'(d);
		end
		return r;
	endfunction

	// hop channel from the bound ID bytes
	function automatic logic [6:0] hop_chan(input logic [1:0] idx, input logic [7:0] id_lo,
		input logic [7:0] id_hi);
		logic [6:0] r;
		unique case (idx)
			2'd0:    r = {3'b000, id_lo[3:0]} + HOP_OFS0;
			2'd1:    r = {3'b000, id_lo[7:4]} + HOP_OFS1;
			2'd2:    r = {3'b000, id_hi[3:0]} + HOP_OFS2;
			default: r = {3'b000, id_hi[7:4]} + HOP_OFS3;
		endcase
		return r;
	endfunction

	// rate scaling, truncated toward zero (works on the magnitude)
	function automatic logic signed [9:0] rate_scale(input logic signed [9:0] v,
		input rate_t mode);
		logic [8:0]        mag;
		logic [24:0]       prod;
		logic [8:0]        q;
		logic signed [9:0] res;
		mag  = v[9] ? 9'(-v) : 9'(v);
		prod = '0;
		unique case (mode)
			RATE_33: begin
				prod = 25'(mag) * 25'(MUL_33);
				q    = prod[24:16];
			end
			RATE_66: begin
				prod = 25'(mag) * 25'(MUL_66);
				q    = prod[24:16];
			end
			default: q = mag;
		endcase
		res = {1'b0, q};
		return v[9] ? -res : res;
	endfunction

endpackage

`default_nettype wire

/* rtl/rc_packet_stick_decoder.sv */
// ----------------------------------------------------------------------------
// rc_packet_stick_decoder
// Collects control packet bytes and emits one decoded stick command per packet.
// ----------------------------------------------------------------------------
// One payload byte is taken per beat, one beat per cycle while s_tready is high.
// A beat with s_tuser set starts a new packet; after PACKET_BYTES bytes the packet
// is complete and the next byte starts a new one. The decoded command passes the
// stage 1 and output registers: the first stage clamps the sticks, updates the
// flip channel and looks up the hop channel, the second applies the rate scale
// with one multiplier per axis. Input stalls only when both stages hold a
// finished packet and the output is not taken. The ID registers are written
// through the cfg port by the user only while idle; the block does not enforce it.
`default_nettype none

module rc_packet_stick_decoder #(
	parameter int unsigned PACKET_BYTES = 19
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// config write port
	input  wire logic                          cfg_we,
	input  wire logic [rcpsd_pkg::CfgAddrW-1:0] cfg_addr,
	input  wire logic [7:0]                    cfg_data,
	// input stream
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [7:0]                    s_tdata,  // [7:0] pkt_byte
	input  wire logic                          s_tuser,  // [0] pkt_start
	// output stream
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// [9:0] throttle_cmd, [19:10] roll_cmd, [29:20] pitch_cmd, [39:30] yaw_cmd,
	// [49:40] aux_cmd, [56:50] hop_channel, [63:57] zero
	output logic [63:0]                        m_tdata
);

	localparam int unsigned PosW = $clog2(PACKET_BYTES);
	localparam logic [PosW-1:0] PosLast = PosW'(PACKET_BYTES - 1);

	logic [PosW-1:0] pos_q;
	logic [PosW-1:0] pos_cur;
	logic            s_acc;
	logic            pkt_done;
	logic            capture;
	logic            advance;

	logic [7:0] store_q [rcpsd_pkg::ByteFirst:rcpsd_pkg::ByteLast];
	logic [7:0] id_lo_q;
	logic [7:0] id_hi_q;
	logic [1:0] hop_q;
	logic signed [9:0] aux_q;

	logic              valid_s1;
	rcpsd_pkg::cmd_t   cmd_s1;
	rcpsd_pkg::cmd_t   cmd_d;
	logic signed [9:0] aux_d;

	logic [15:0]       thr_word;
	logic [16:0]       thr_off;
	logic signed [16:0] roll_off;
	logic signed [16:0] pitch_off;
	logic signed [16:0] yaw_off;

	// handshake
	assign advance  = !m_tvalid || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign s_acc    = s_tvalid && s_tready;
	assign pos_cur  = s_tuser ? '0 : pos_q;
	assign pkt_done = (pos_cur == PosLast);
	assign capture  = s_acc && pkt_done;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_lo_q <= '0;
			id_hi_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				rcpsd_pkg::REG_ID_LOW:  id_lo_q <= cfg_data;
				rcpsd_pkg::REG_ID_HIGH: id_hi_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// byte position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (s_acc) begin
			pos_q <= pkt_done ? '0 : pos_cur + 1'b1;
		end
	end

	// byte store, only the positions that carry data
	for (genvar i = rcpsd_pkg::ByteFirst; i <= rcpsd_pkg::ByteLast; i++) begin : g_store
		always_ff @(posedge clk) begin
			if (s_acc && (pos_cur == PosW'(i))) begin
				store_q[i] <= s_tdata;
			end
		end
	end

	// stage 1: offsets, clamps, flip channel, hop lookup, rate mode
	always_comb begin
		thr_word  = {store_q[rcpsd_pkg::BYTE_THR_H], store_q[rcpsd_pkg::BYTE_THR_L]};
		thr_off   = {1'b0, thr_word} - {1'b0, rcpsd_pkg::THR_LOW};
		roll_off  = $signed({store_q[rcpsd_pkg::BYTE_ROLL_H][7],
			store_q[rcpsd_pkg::BYTE_ROLL_H], store_q[rcpsd_pkg::BYTE_ROLL_L]})
			- rcpsd_pkg::STICK_MID;
		pitch_off = $signed({store_q[rcpsd_pkg::BYTE_PIT_H][7],
			store_q[rcpsd_pkg::BYTE_PIT_H], store_q[rcpsd_pkg::BYTE_PIT_L]})
			- rcpsd_pkg::STICK_MID;
		yaw_off   = $signed({5'b00000, store_q[rcpsd_pkg::BYTE_FLAGS][3:0],
			store_q[rcpsd_pkg::BYTE_YAW_L]}) - rcpsd_pkg::STICK_MID;

		if (thr_word < rcpsd_pkg::THR_LOW) begin
			cmd_d.thr = '0;
		end else if (thr_word > rcpsd_pkg::THR_HIGH) begin
			cmd_d.thr = 10'd1000;
		end else begin
			cmd_d.thr = thr_off[9:0];
		end
		cmd_d.roll  = -rcpsd_pkg::clamp_stick(roll_off);
		cmd_d.pitch = -rcpsd_pkg::clamp_stick(pitch_off);
		cmd_d.yaw   = rcpsd_pkg::clamp_stick(yaw_off);

		// flip latch on unscaled pitch
		aux_d = aux_q;
		if (store_q[rcpsd_pkg::BYTE_FLAGS][rcpsd_pkg::FLIP_BIT]) begin
			if (cmd_d.pitch > rcpsd_pkg::FLIP_LIM) begin
				aux_d = rcpsd_pkg::AUX_POS;
			end else if (cmd_d.pitch < -rcpsd_pkg::FLIP_LIM) begin
				aux_d = rcpsd_pkg::AUX_NEG;
			end
		end
		cmd_d.aux = aux_d;
		cmd_d.hop = rcpsd_pkg::hop_chan(hop_q, id_lo_q, id_hi_q);

		priority if (store_q[rcpsd_pkg::BYTE_MODE] == rcpsd_pkg::MODE_33_CODE) begin
			cmd_d.mode = rcpsd_pkg::RATE_33;
		end else if (store_q[rcpsd_pkg::BYTE_MODE] == rcpsd_pkg::MODE_66_CODE) begin
			cmd_d.mode = rcpsd_pkg::RATE_66;
		end else begin
			cmd_d.mode = rcpsd_pkg::RATE_ONE;
		end
	end

	// packet state: flip hold and hop index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aux_q <= '0;
			hop_q <= rcpsd_pkg::HOP_RESET;
		end else if (capture) begin
			aux_q <= aux_d;
			hop_q <= hop_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (capture) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			cmd_s1 <= cmd_d;
		end
	end

	// stage 2: rate scale into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			m_tdata <= {7'b0000000, cmd_s1.hop, cmd_s1.aux,
				rcpsd_pkg::rate_scale(cmd_s1.yaw, cmd_s1.mode),
				rcpsd_pkg::rate_scale(cmd_s1.pitch, cmd_s1.mode),
				rcpsd_pkg::rate_scale(cmd_s1.roll, cmd_s1.mode),
				cmd_s1.thr};
		end
	end

	// checks
	a_aux_range: assert property (@(posedge clk) disable iff (!arst_n)
		aux_q == 10'sd0 || aux_q == rcpsd_pkg::AUX_POS || aux_q == rcpsd_pkg::AUX_NEG)
		else $error("flip channel left its three values");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= PosLast)
		else $error("byte position beyond packet length");

	a_capture_s1: assert property (@(posedge clk) disable iff (!arst_n)
		capture |=> valid_s1)
		else $error("completed packet not held in stage 1");

	a_hop_step: assert property (@(posedge clk) disable iff (!arst_n)
		capture |=> hop_q == 2'($past(hop_q) + 2'd1))
		else $error("hop index did not advance on packet");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> valid_s1)
		else $error("stage 1 packet lost under stall");

endmodule

`default_nettype wire

/* bench/tb_rc_packet_stick_decoder.sv */
// ----------------------------------------------------------------------------
// tb_rc_packet_stick_decoder
// Self-checking bench for the stick packet decoder.
// ----------------------------------------------------------------------------
// Payload bytes are streamed in as beats: first a directed table of packets
// covering stick extremes, clamps, rate modes, flip thresholds, a restart
// mid packet and a packet without a start mark. Then random traffic, mostly
// well formed packets with random content, mixed with abandoned partial
// packets and noise. A bench-side decoder tracks byte position, hop index,
// the flip channel and the ID registers, and every output beat is compared
// field by field with the oldest pending command. Both stream sides stall
// at random; one phase runs without stalls. ID registers are rewritten
// between phases while the decoder is idle.
// ----------------------------------------------------------------------------

module tb_rc_packet_stick_decoder;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PACKET_BYTES  = 19;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_BEATS   = 420;
	localparam int IDLE_PCT      = 21;

	// register indexes past the last one, to be ignored
	localparam logic [rcpsd_pkg::CfgAddrW-1:0] REG_SPARE_A = 2'd2;
	localparam logic [rcpsd_pkg::CfgAddrW-1:0] REG_SPARE_B = 2'd3;

	// mode bytes that leave the sticks unscaled
	localparam logic [7:0] MODE_FLAT     = 8'h02;
	localparam logic [7:0] MODE_FLAT_ALL = 8'hFF;
	localparam logic [7:0] FLIP_MASK     = 8'h01 << rcpsd_pkg::FLIP_BIT;

	typedef struct packed {
		int thr;
		int roll;
		int pitch;
		int yaw;
		int aux;
		int hop;
	} stick_cmd_t;

	typedef struct packed {
		bit         known;
		stick_cmd_t cmd;
	} typed_cmd_t;

	typedef struct packed {
		logic [15:0] roll_w;
		logic [15:0] pitch_w;
		logic [15:0] thr_w;
		logic [7:0]  yaw_l;
		logic [7:0]  flags;
		logic [7:0]  mode;
		int          cut;
		bit          start;
		bit          known;
		stick_cmd_t  cmd;
	} pkt_row_t;

	logic                           clk;
	logic                           arst_n   = 1'b0;
	logic                           cfg_we   = 1'b0;
	logic [rcpsd_pkg::CfgAddrW-1:0] cfg_addr = '0;
	logic [7:0]                     cfg_data = '0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [7:0]                     s_tdata  = '0;
	logic                           s_tuser  = 1'b0;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [63:0]                    m_tdata;

	// bench-side decoder state
	logic [7:0] pkt_mem [PACKET_BYTES];
	int         pkt_pos  = 0;
	logic [1:0] hop_idx  = rcpsd_pkg::HOP_RESET;
	int         aux_hold = 0;
	logic [7:0] id_lo    = '0;
	logic [7:0] id_hi    = '0;

	stick_cmd_t cmd_due_q [$];
	typed_cmd_t typed_q [$];
	stick_cmd_t head_cmd;
	pkt_row_t   directed_rows [13];

	int errors      = 0;
	int cycle_count = 0;
	int beats_sent  = 0;
	bit calm        = 1'b0;

	rc_packet_stick_decoder #(
		.PACKET_BYTES(PACKET_BYTES)
	) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int clamp_int(input int v, input int lo, input int hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic int scale_rate(input int v, input logic [7:0] mode);
		if (mode == rcpsd_pkg::MODE_33_CODE) return (v * 33) / 100;
		if (mode == rcpsd_pkg::MODE_66_CODE) return (v * 66) / 100;
		return v;
	endfunction

	function automatic void check_field(input string name, input int due, input int got);
		if (due != got) begin
			$error("%s: expected %0d, actual %0d", name, due, got);
			errors++;
		end
	endfunction

	// decode one accepted payload byte; a complete packet queues its command
	task automatic decode_byte(input logic [7:0] b, input logic start);
		stick_cmd_t c;
		typed_cmd_t t;
		logic [7:0] mode;
		if (start) pkt_pos = 0;
		if (pkt_pos >= PACKET_BYTES) pkt_pos = 0;
		pkt_mem[pkt_pos] = b;
		pkt_pos++;
		if (pkt_pos == PACKET_BYTES) begin
			pkt_pos = 0;
			c.thr   = clamp_int(int'({pkt_mem[rcpsd_pkg::BYTE_THR_H],
				pkt_mem[rcpsd_pkg::BYTE_THR_L]}) - 1000, 0, 1000);
			c.roll  = -clamp_int(int'($signed({pkt_mem[rcpsd_pkg::BYTE_ROLL_H],
				pkt_mem[rcpsd_pkg::BYTE_ROLL_L]})) - 1500, -500, 500);
			c.pitch = -clamp_int(int'($signed({pkt_mem[rcpsd_pkg::BYTE_PIT_H],
				pkt_mem[rcpsd_pkg::BYTE_PIT_L]})) - 1500, -500, 500);
			c.yaw   = clamp_int(int'({pkt_mem[rcpsd_pkg::BYTE_FLAGS][3:0],
				pkt_mem[rcpsd_pkg::BYTE_YAW_L]}) - 1500, -500, 500);
			// flip channel latches on the unscaled pitch
			if ((pkt_mem[rcpsd_pkg::BYTE_FLAGS] & FLIP_MASK) != 0) begin
				if (c.pitch > 450) aux_hold = 500;
				if (c.pitch < -450) aux_hold = -500;
			end
			mode    = pkt_mem[rcpsd_pkg::BYTE_MODE];
			c.roll  = scale_rate(c.roll, mode);
			c.pitch = scale_rate(c.pitch, mode);
			c.yaw   = scale_rate(c.yaw, mode);
			c.aux   = aux_hold;
			case (hop_idx)
				2'd0:    c.hop = int'(id_lo[3:0]) + int'(rcpsd_pkg::HOP_OFS0);
				2'd1:    c.hop = int'(id_lo[7:4]) + int'(rcpsd_pkg::HOP_OFS1);
				2'd2:    c.hop = int'(id_hi[3:0]) + int'(rcpsd_pkg::HOP_OFS2);
				default: c.hop = int'(id_hi[7:4]) + int'(rcpsd_pkg::HOP_OFS3);
			endcase
			hop_idx = hop_idx + 2'd1;
			// directed rows may carry a hand-typed command instead
			if (typed_q.size() != 0) begin
				t = typed_q.pop_front();
				if (t.known) c = t.cmd;
			end
			cmd_due_q.push_back(c);
		end
	endtask

	// sample both stream sides and the config port at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (cmd_due_q.size() == 0) begin
					$error("output beat with no command pending: m_tdata %h", m_tdata);
					errors++;
				end else begin
					head_cmd = cmd_due_q.pop_front();
					check_field("throttle_cmd", head_cmd.thr, int'(m_tdata[9:0]));
					check_field("roll_cmd", head_cmd.roll, int'($signed(m_tdata[19:10])));
					check_field("pitch_cmd", head_cmd.pitch, int'($signed(m_tdata[29:20])));
					check_field("yaw_cmd", head_cmd.yaw, int'($signed(m_tdata[39:30])));
					check_field("aux_cmd", head_cmd.aux, int'($signed(m_tdata[49:40])));
					check_field("hop_channel", head_cmd.hop, int'(m_tdata[56:50]));
				end
			end
			if (s_tvalid && s_tready) decode_byte(s_tdata, s_tuser);
			if (cfg_we) begin
				case (cfg_addr)
					rcpsd_pkg::REG_ID_LOW:  id_lo = cfg_data;
					rcpsd_pkg::REG_ID_HIGH: id_hi = cfg_data;
					default:                ;
				endcase
			end
		end
	end

	// output side stalls
	always @(negedge clk) m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_rc_packet_stick_decoder failed");
			$finish;
		end
	end

	// one input beat, with random gaps ahead of it
	task automatic send_beat(input logic [7:0] b, input logic start);
		@(negedge clk);
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= start;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		beats_sent++;
	endtask

	task automatic send_packet(input logic [15:0] roll_w, input logic [15:0] pitch_w,
		input logic [15:0] thr_w, input logic [7:0] yaw_l, input logic [7:0] flags,
		input logic [7:0] mode, input logic start);
		logic [7:0] b;
		for (int k = 0; k < PACKET_BYTES; k++) begin
			b = 8'($urandom);
			case (k)
				rcpsd_pkg::BYTE_ROLL_L: b = roll_w[7:0];
				rcpsd_pkg::BYTE_ROLL_H: b = roll_w[15:8];
				rcpsd_pkg::BYTE_PIT_L:  b = pitch_w[7:0];
				rcpsd_pkg::BYTE_PIT_H:  b = pitch_w[15:8];
				rcpsd_pkg::BYTE_THR_L:  b = thr_w[7:0];
				rcpsd_pkg::BYTE_THR_H:  b = thr_w[15:8];
				rcpsd_pkg::BYTE_YAW_L:  b = yaw_l;
				rcpsd_pkg::BYTE_FLAGS:  b = flags;
				rcpsd_pkg::BYTE_MODE:   b = mode;
				default:                ;
			endcase
			send_beat(b, start && (k == 0));
		end
	endtask

	task automatic write_reg(input logic [rcpsd_pkg::CfgAddrW-1:0] addr,
		input logic [7:0] data);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_addr <= addr;
		cfg_data <= data;
		@(negedge clk);
		cfg_we   <= 1'b0;
	endtask

	// stop sending and wait for every pending command
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (cmd_due_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// stick word biased toward the interesting range
	function automatic logic [15:0] pick_word();
		logic [15:0] edges [11] = '{16'd0, 16'd1000, 16'd1049, 16'd1050, 16'd1500,
			16'd1950, 16'd1951, 16'd2000, 16'hFFFF, 16'h8000, 16'h7FFF};
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return 16'(900 + $urandom_range(0, 1200));
			6, 7:             return 16'($urandom);
			default:          return edges[$urandom_range(0, 10)];
		endcase
	endfunction

	task automatic random_traffic(input int beats);
		int         stop_at;
		int         kind;
		int         n;
		logic [7:0] mode;
		stop_at = beats_sent + beats;
		while (beats_sent < stop_at) begin
			kind = $urandom_range(0, 99);
			if (kind < 80) begin
				case ($urandom_range(0, 3))
					0:       mode = rcpsd_pkg::MODE_33_CODE;
					1:       mode = rcpsd_pkg::MODE_66_CODE;
					default: mode = 8'($urandom);
				endcase
				send_packet(pick_word(), pick_word(), pick_word(), 8'($urandom), 8'($urandom),
					mode, $urandom_range(0, 9) != 0);
			end else if (kind < 90) begin
				// partial packet, abandoned by the next start
				n = $urandom_range(1, PACKET_BYTES - 1);
				for (int k = 0; k < n; k++) send_beat(8'($urandom), k == 0);
			end else begin
				// noise with stray start marks
				n = $urandom_range(1, 30);
				for (int k = 0; k < n; k++) send_beat(8'($urandom), $urandom_range(0, 7) == 0);
			end
		end
	endtask

	initial begin
		typed_cmd_t t;

		// roll, pitch, thr, yaw low, flags, mode, cut, start, known, {thr,roll,pitch,yaw,aux,hop}
		directed_rows[0]  = '{16'd1500, 16'd1500, 16'd1000, 8'hDC, 8'h05, MODE_FLAT,
			0, 1'b1, 1'b1, '{0, 0, 0, 0, 0, 22}};
		directed_rows[1]  = '{16'd2000, 16'd2000, 16'd2000, 8'hD0, 8'h07, MODE_FLAT,
			0, 1'b1, 1'b1, '{1000, -500, -500, 500, 0, 45}};
		directed_rows[2]  = '{16'd1000, 16'd1000, 16'd0, 8'h00, FLIP_MASK, MODE_FLAT,
			0, 1'b1, 1'b1, '{0, 500, 500, -500, 500, 64}};
		// negative words and all-ones bytes
		directed_rows[3]  = '{16'hFFFF, 16'h8000, 16'hFFFF, 8'hFF, 8'hFF, MODE_FLAT_ALL,
			0, 1'b1, 1'b1, '{1000, 500, 500, 500, 500, 3}};
		directed_rows[4]  = '{16'h7FFF, 16'd2000, 16'd1001, 8'hDC, FLIP_MASK | 8'h05, MODE_FLAT,
			0, 1'b1, 1'b1, '{1, -500, -500, 0, -500, 22}};
		directed_rows[5]  = '{16'd1000, 16'd2000, 16'd1999, 8'hD0, 8'h07,
			rcpsd_pkg::MODE_33_CODE, 0, 1'b1, 1'b1, '{999, 165, -165, 165, -500, 45}};
		directed_rows[6]  = '{16'd1000, 16'd2000, 16'd1500, 8'hD0, 8'h07,
			rcpsd_pkg::MODE_66_CODE, 0, 1'b1, 1'b1, '{500, 330, -330, 330, -500, 64}};
		// flip thresholds, truncation toward zero
		directed_rows[7]  = '{16'd1499, 16'd1050, 16'd999, 8'hDD, FLIP_MASK | 8'h05, MODE_FLAT,
			0, 1'b1, 1'b1, '{0, 1, 450, 1, -500, 3}};
		directed_rows[8]  = '{16'd1501, 16'd1049, 16'd1000, 8'hDB, FLIP_MASK | 8'h05,
			rcpsd_pkg::MODE_33_CODE, 0, 1'b1, 1'b1, '{0, 0, 148, 0, 500, 22}};
		directed_rows[9]  = '{16'd1003, 16'd1951, 16'd2001, 8'hCD, FLIP_MASK | 8'h07,
			rcpsd_pkg::MODE_66_CODE, 0, 1'b1, 1'b1, '{1000, 328, -297, 328, -500, 45}};
		// restart mid packet, packet with no start mark, unused flag bits
		directed_rows[10] = '{16'd1234, 16'd1777, 16'd1420, 8'h40, FLIP_MASK | 8'h06,
			rcpsd_pkg::MODE_33_CODE, 7, 1'b1, 1'b0, '{0, 0, 0, 0, 0, 0}};
		directed_rows[11] = '{16'd1600, 16'd1300, 16'd1800, 8'h20, 8'h05,
			rcpsd_pkg::MODE_66_CODE, 0, 1'b0, 1'b0, '{0, 0, 0, 0, 0, 0}};
		directed_rows[12] = '{16'd1111, 16'd1999, 16'd500, 8'hFF, 8'hF7, MODE_FLAT_ALL,
			0, 1'b1, 1'b0, '{0, 0, 0, 0, 0, 0}};

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed packets with ID registers at reset
		foreach (directed_rows[r]) begin
			for (int k = 0; k < directed_rows[r].cut; k++) send_beat(8'($urandom), k == 0);
			t.known = directed_rows[r].known;
			t.cmd   = directed_rows[r].cmd;
			typed_q.push_back(t);
			send_packet(directed_rows[r].roll_w, directed_rows[r].pitch_w, directed_rows[r].thr_w,
				directed_rows[r].yaw_l, directed_rows[r].flags, directed_rows[r].mode,
				directed_rows[r].start);
		end
		settle();

		// top ID values, spare indexes must not disturb them
		write_reg(rcpsd_pkg::REG_ID_LOW, 8'hFF);
		write_reg(rcpsd_pkg::REG_ID_HIGH, 8'hFF);
		write_reg(REG_SPARE_A, 8'($urandom));
		write_reg(REG_SPARE_B, 8'($urandom));
		random_traffic(PHASE_BEATS);
		settle();

		// split nibbles, no stalls on either side
		write_reg(rcpsd_pkg::REG_ID_LOW, 8'h0F);
		write_reg(rcpsd_pkg::REG_ID_HIGH, 8'hF0);
		calm = 1'b1;
		random_traffic(PHASE_BEATS);
		settle();
		calm = 1'b0;

		write_reg(rcpsd_pkg::REG_ID_LOW, 8'($urandom));
		write_reg(rcpsd_pkg::REG_ID_HIGH, 8'($urandom));
		random_traffic(PHASE_BEATS);
		settle();

		write_reg(rcpsd_pkg::REG_ID_LOW, 8'h00);
		write_reg(rcpsd_pkg::REG_ID_HIGH, 8'h00);
		random_traffic(PHASE_BEATS);
		settle();

		if (errors == 0 && cmd_due_q.size() == 0) begin
			$display("tb_rc_packet_stick_decoder passed");
		end else begin
			$display("tb_rc_packet_stick_decoder failed");
		end
		$finish;
	end

endmodule

/* files.f */
rtl/rcpsd_pkg.sv
rtl/rc_packet_stick_decoder.sv
bench/tb_rc_packet_stick_decoder.sv
